### rtl/pidsv_pkg.sv
// Package for the PID servo axis controller: register indexes and fixed widths.
// No dependencies.
package pidsv_pkg;
  localparam int unsigned CfgIdxW = 3;
  typedef enum logic [CfgIdxW-1:0] {
    REG_TARGET = 3'd0,
    REG_KP     = 3'd1,
    REG_KI     = 3'd2,
    REG_KD     = 3'd3,
    REG_CENTER = 3'd4,
    REG_LOWER  = 3'd5,
    REG_UPPER  = 3'd6
  } cfg_reg_t;
  localparam int unsigned AngleW = 32;
  localparam int unsigned GainW  = 24;
  localparam int unsigned PosW   = 8;
  localparam logic [PosW-1:0] ServoMax = 8'd180;
endpackage

### rtl/pid_servo_axis_controller_core.sv
// PID servo axis controller core: bit-serial multiplies and restoring divide.
// Depends on pidsv_pkg.
//
// One transaction in gives one servo position out. Each item runs through a
// sequencer built around one shift-add multiplier (one multiplier bit per
// cycle, the 128-bit accumulator shifting right through a 65-bit adder) and
// one restoring divider (one quotient bit per cycle). After a setup step come
// the multiplies Kp*e, |Ki|*|sum|, times dt and Kd*de, then the divide by dt,
// the sum step and the clamp step. A new item is accepted only in the idle
// state, so the core takes no new item before the last has passed the clamp
// step. The finished result waits in a one-entry pending register while the
// output register is still held; the clamp step stalls while the pending
// register is full, until the output is taken.
module pid_servo_axis_controller_core
  import pidsv_pkg::*;
#(
  parameter int unsigned SUM_WIDTH = 48
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] measured_angle,
  input  logic [31:0]        time_ms,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [PosW-1:0]    servo_position
);
  localparam int unsigned CntW = 7;
  localparam logic [63:0] ItermLimit = 64'h2000_0000_0000_0000;

  typedef enum logic [3:0] {
    S_IDLE, S_SETUP, S_PMUL, S_IMUL1, S_IMUL2, S_DMUL, S_DDIV, S_SUM, S_CLAMP, S_DONE
  } state_t;

  state_t state;
  logic [CntW-1:0] cnt;

  logic signed [31:0] target;
  logic signed [GainW-1:0] kp, ki, kd;
  logic [PosW-1:0] center, lower, upper;

  logic signed [SUM_WIDTH-1:0] error_sum;
  logic signed [32:0] previous_error;
  logic [31:0] previous_time;

  logic signed [32:0] err;
  logic [31:0] dt;
  // shared shift-add multiplier: add mcand to the high half, shift right
  logic [127:0] acc;
  logic [63:0]  mcand;
  logic [63:0]  mplier;
  logic         neg;      // sign of current product
  logic signed [65:0] pterm, iterm, dterm;
  // divider
  logic [63:0] quo;
  logic [32:0] rem;
  logic        pend_valid;
  logic [PosW-1:0] pend;

  logic signed [SUM_WIDTH:0] sum_ext;
  logic signed [SUM_WIDTH-1:0] sum_sat;
  logic signed [33:0] derr;
  logic [32:0] rem_sh;
  logic signed [67:0] total;
  logic [64:0]  mac_sum;
  logic [127:0] acc_next;

  localparam logic signed [SUM_WIDTH-1:0] SumMax = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_WIDTH-1:0] SumMin = {1'b1, {(SUM_WIDTH-1){1'b0}}};

  always_comb begin
    sum_ext = {error_sum[SUM_WIDTH-1], error_sum}
              + {{(SUM_WIDTH+1-33){err[32]}}, err};
    if (sum_ext[SUM_WIDTH] != sum_ext[SUM_WIDTH-1])
      sum_sat = sum_ext[SUM_WIDTH] ? SumMin : SumMax;
    else
      sum_sat = sum_ext[SUM_WIDTH-1:0];
    derr = {err[32], err} - {previous_error[32], previous_error};
    rem_sh = {rem[31:0], quo[63]};
    mac_sum = {1'b0, acc[127:64]} + (mplier[0] ? {1'b0, mcand} : 65'd0);
    acc_next = {mac_sum, acc[63:1]};
    total = {{2{pterm[65]}}, pterm} + {{2{iterm[65]}}, iterm}
            + {{2{dterm[65]}}, dterm} + {28'd0, center, 32'd0};
  end

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; cnt <= '0;
      target <= '0; kp <= '0; ki <= '0; kd <= '0;
      center <= 8'd90; lower <= '0; upper <= ServoMax;
      error_sum <= '0; previous_error <= '0; previous_time <= '0;
      out_valid <= 1'b0; pend_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_TARGET: target <= cfg_data;
          REG_KP:     kp <= cfg_data[GainW-1:0];
          REG_KI:     ki <= cfg_data[GainW-1:0];
          REG_KD:     kd <= cfg_data[GainW-1:0];
          REG_CENTER: center <= cfg_data[PosW-1:0];
          REG_LOWER:  lower <= cfg_data[PosW-1:0];
          REG_UPPER:  upper <= cfg_data[PosW-1:0];
          default: ;
        endcase
      end
      if (pend_valid && (!out_valid || out_ready)) begin
        out_valid <= 1'b1; servo_position <= pend; pend_valid <= 1'b0;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: if (in_valid) begin
          err <= {target[31], target} - {measured_angle[31], measured_angle};
          if (time_ms == previous_time) begin
            dt <= 32'd1; previous_time <= time_ms + 32'd1;
          end else begin
            dt <= time_ms - previous_time; previous_time <= time_ms;
          end
          state <= S_SETUP;
        end
        S_SETUP: begin
          error_sum <= sum_sat;
          // Kp*err on magnitudes
          neg <= kp[GainW-1] ^ err[32];
          mcand <= 64'(kp[GainW-1] ? -{{40{kp[GainW-1]}}, kp} : {40'd0, kp});
          mplier <= 64'(err[32] ? -{{31{err[32]}}, err} : {31'd0, err});
          acc <= '0; cnt <= '0; state <= S_PMUL;
        end
        S_PMUL, S_IMUL1, S_IMUL2, S_DMUL: begin
          if (cnt != CntW'(63)) begin
            acc <= acc_next;
            mplier <= {1'b0, mplier[63:1]};
            cnt <= cnt + 1'b1;
          end else begin
            // last multiplier bit: acc_next holds the full product
            cnt <= '0;
            unique case (state)
              S_PMUL: begin
                pterm <= neg ? -66'(acc_next[63:0]) : 66'(acc_next[63:0]);
                neg <= ki[GainW-1] ^ error_sum[SUM_WIDTH-1];
                mcand <= 64'(ki[GainW-1] ? -{{40{ki[GainW-1]}}, ki} : {40'd0, ki});
                mplier <= error_sum[SUM_WIDTH-1]
                          ? 64'(-{{(65-SUM_WIDTH){error_sum[SUM_WIDTH-1]}}, error_sum})
                          : 64'({{(65-SUM_WIDTH){1'b0}}, error_sum});
                acc <= '0; state <= S_IMUL1;
              end
              S_IMUL1: begin
                mcand <= (acc_next[127:64] != '0 || acc_next[63:0] > ItermLimit)
                         ? ItermLimit : acc_next[63:0];
                mplier <= {32'd0, dt};
                acc <= '0; state <= S_IMUL2;
              end
              S_IMUL2: begin
                if (acc_next[127:64] != '0 || acc_next[63:0] > ItermLimit)
                  iterm <= neg ? -66'(ItermLimit) : 66'(ItermLimit);
                else
                  iterm <= neg ? -66'(acc_next[63:0]) : 66'(acc_next[63:0]);
                neg <= kd[GainW-1] ^ derr[33];
                mcand <= 64'(kd[GainW-1] ? -{{40{kd[GainW-1]}}, kd} : {40'd0, kd});
                mplier <= 64'(derr[33] ? -{{30{derr[33]}}, derr} : {30'd0, derr});
                acc <= '0; state <= S_DMUL;
              end
              default: begin
                quo <= acc_next[63:0]; rem <= '0; state <= S_DDIV;
              end
            endcase
          end
        end
        S_DDIV: begin
          // restoring divide, one quotient bit per cycle
          if (rem_sh >= {1'b0, dt}) begin
            rem <= rem_sh - {1'b0, dt}; quo <= {quo[62:0], 1'b1};
          end else begin
            rem <= rem_sh; quo <= {quo[62:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == CntW'(63)) state <= S_SUM;
        end
        S_SUM: begin
          dterm <= neg ? -66'(quo) : 66'(quo);
          state <= S_CLAMP;
        end
        S_CLAMP: if (!pend_valid) begin
          if (total < $signed({28'd0, lower, 32'd0})) pend <= (lower > ServoMax) ? ServoMax : lower;
          else if (total > $signed({28'd0, upper, 32'd0}))
            pend <= (upper > ServoMax) ? ServoMax : upper;
          else pend <= (total[39:32] > ServoMax) ? ServoMax : total[39:32];
          pend_valid <= 1'b1;
          previous_error <= err;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) (state == S_DDIV) |-> (dt != '0))
    else $error("zero time step in divider");
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_SETUP))
    else $error("accepted item did not start");
  assert property (@(posedge clk) disable iff (rst) out_valid |-> (servo_position <= ServoMax))
    else $error("servo position out of range");
endmodule
